### design/iba_pkg.sv
// ----------------------------------------------------------------------------
// iba_pkg: shared types and codes for the inode block allocator
// Transfer payloads, allocator codes and the bitmap command/response types.
// ----------------------------------------------------------------------------
package iba_pkg;

  // Input modes
  localparam logic [1:0] MODE_ALLOC  = 2'd0;
  localparam logic [1:0] MODE_FREE   = 2'd1;
  localparam logic [1:0] MODE_RESIZE = 2'd2;

  // Block events
  localparam logic [1:0] EV_NONE    = 2'd0;
  localparam logic [1:0] EV_ALLOC   = 2'd1;
  localparam logic [1:0] EV_RELEASE = 2'd2;

  // Status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_TOO_MANY = 3'd1;
  localparam logic [2:0] ST_UNUSED   = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_NO_INODE = 3'd4;

  // Widest bitmap index (covers up to 4096 entries)
  localparam int BmIdxW = 12;

  typedef enum logic [1:0] {
    BM_FIND,   // find lowest clear bit and set it
    BM_CLEAR,  // clear one bit, report its old value
    BM_TEST    // read one bit
  } iba_bm_op_e;

  typedef struct packed {
    iba_bm_op_e          op;
    logic [BmIdxW-1:0]   idx;
  } iba_bm_cmd_t;

  typedef struct packed {
    logic                found;
    logic                prev;
    logic [BmIdxW-1:0]   idx;
  } iba_bm_rsp_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  inode;
    logic [15:0] size_bytes;
  } iba_in_t;

  typedef struct packed {
    logic [9:0] block;
    logic [1:0] block_event;
    logic [7:0] inode_out;
    logic [2:0] status;
    logic       last;
  } iba_out_t;

endpackage

### design/iba_bitmap.sv
// ----------------------------------------------------------------------------
// iba_bitmap: word-organized usage bitmap
// One synchronous RAM of W-bit rows plus a per-row full flag. Supports
// find-lowest-free-and-set, clear and test, each as a read-modify-write
// (test writes nothing back). A clearing pass loads the reset pattern after reset.
// ----------------------------------------------------------------------------
module iba_bitmap #(
  parameter int DEPTH  = 1024,
  parameter int SET_LO = 0,
  parameter int SET_HI = 19
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cmd_valid_i,
  input  iba_pkg::iba_bm_cmd_t cmd_i,
  output logic                 ready_o,
  output logic                 rsp_valid_o,
  output iba_pkg::iba_bm_rsp_t rsp_o
);

  localparam int W    = (DEPTH < 32) ? DEPTH : 32;
  localparam int ROWS = DEPTH / W;
  localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int BW   = $clog2(W);
  localparam int IW   = $clog2(DEPTH);

  localparam logic [1:0] ST_INIT = 2'd0;
  localparam logic [1:0] ST_IDLE = 2'd1;
  localparam logic [1:0] ST_RMW  = 2'd2;

  logic [1:0]           state_q;
  logic [RW-1:0]        cnt_q;
  logic [RW-1:0]        row_q;
  logic [BW-1:0]        bit_q;
  iba_pkg::iba_bm_op_e  op_q;
  logic [ROWS-1:0]      full_q;
  logic                 rsp_valid_q;
  iba_pkg::iba_bm_rsp_t rsp_q;

  logic [W-1:0]  mem [ROWS];
  logic [W-1:0]  rdata_q;
  logic          we;
  logic [RW-1:0] waddr;
  logic [W-1:0]  wdata;
  logic [RW-1:0] raddr;

  logic [RW-1:0] free_row;
  logic          any_free;
  logic [BW-1:0] zero_bit;
  logic [W-1:0]  init_word;
  logic [IW-1:0] cmd_idx;
  logic [RW-1:0] cmd_row;
  logic          find_none;

  assign cmd_idx   = cmd_i.idx[IW-1:0];
  assign cmd_row   = RW'(cmd_idx >> BW);
  assign find_none = (cmd_i.op == iba_pkg::BM_FIND) && !any_free;

  // Lowest row that still has a clear bit
  always_comb begin
    free_row = '0;
    any_free = 1'b0;
    for (int r = ROWS - 1; r >= 0; r--) begin
      if (!full_q[r]) begin
        free_row = RW'(r);
        any_free = 1'b1;
      end
    end
  end

  // Lowest clear bit of the row just read
  always_comb begin
    zero_bit = '0;
    for (int j = W - 1; j >= 0; j--) begin
      if (!rdata_q[j]) begin
        zero_bit = BW'(j);
      end
    end
  end

  // Reset pattern of the row being initialized
  always_comb begin
    for (int j = 0; j < W; j++) begin
      init_word[j] = ((int'(cnt_q) * W + j) >= SET_LO) && ((int'(cnt_q) * W + j) < SET_HI);
    end
  end

  // RAM port control
  always_comb begin
    we    = 1'b0;
    waddr = row_q;
    wdata = rdata_q;
    raddr = row_q;
    case (state_q)
      ST_INIT: begin
        we    = 1'b1;
        waddr = cnt_q;
        wdata = init_word;
      end
      ST_IDLE: begin
        raddr = (cmd_i.op == iba_pkg::BM_FIND) ? free_row : cmd_row;
      end
      ST_RMW: begin
        case (op_q)
          iba_pkg::BM_FIND: begin
            we              = 1'b1;
            wdata[zero_bit] = 1'b1;
          end
          iba_pkg::BM_CLEAR: begin
            we           = 1'b1;
            wdata[bit_q] = 1'b0;
          end
          default: begin
            we = 1'b0;
          end
        endcase
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  // Bitmap RAM
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      cnt_q       <= '0;
      rsp_valid_q <= 1'b0;
      for (int r = 0; r < ROWS; r++) begin
        full_q[r] <= (SET_LO <= r * W) && ((r * W + W) <= SET_HI);
      end
    end else begin
      case (state_q)
        ST_INIT: begin
          rsp_valid_q <= 1'b0;
          cnt_q       <= RW'(cnt_q + 1'b1);
          if (cnt_q == RW'(ROWS - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          // A find with every row full answers at once with no bit found
          rsp_valid_q <= cmd_valid_i && find_none;
          if (cmd_valid_i && !find_none) begin
            state_q <= ST_RMW;
          end
        end
        ST_RMW: begin
          rsp_valid_q <= 1'b1;
          state_q     <= ST_IDLE;
          if (op_q == iba_pkg::BM_FIND) begin
            full_q[row_q] <= &wdata;
          end else if (op_q == iba_pkg::BM_CLEAR) begin
            full_q[row_q] <= 1'b0;
          end
        end
        default: begin
          rsp_valid_q <= 1'b0;
          state_q     <= ST_IDLE;
        end
      endcase
    end
  end

  // Command and response payload
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && cmd_valid_i) begin
      row_q     <= raddr;
      bit_q     <= cmd_idx[BW-1:0];
      op_q      <= cmd_i.op;
      rsp_q     <= '0;
    end
    if (state_q == ST_RMW) begin
      rsp_q.found <= 1'b1;
      rsp_q.prev  <= rdata_q[bit_q];
      rsp_q.idx   <= iba_pkg::BmIdxW'({row_q, zero_bit});
    end
  end

  assign ready_o     = (state_q == ST_IDLE);
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule

### design/inode_block_allocator.sv
// ----------------------------------------------------------------------------
// inode_block_allocator: bitmap block and inode allocator
// Inode and block bitmaps, per-inode direct block lists, free-block count.
// ----------------------------------------------------------------------------
// One item is worked at a time; in_ready_o is high only between items.
// Mode 3, a resize over the block limit or an inode out of range goes
// straight to its result. Allocate does a find in the inode bitmap. A free
// or resize first tests the inode bit; an unused inode, a failed check or a
// resize that changes nothing then gives its result. A resize that grows
// runs a find in the block bitmap for each new block, and one that shrinks,
// like a free, reads the block list and clears the block bit for each block
// released; each block gives one result. A free of an inode then clears
// its bit in the inode bitmap. The time is set by the read-modify-write of a
// bitmap RAM for every block and inode touched, plus the result transfers;
// any hold-off of a result by out_ready_i adds to it. After reset both
// bitmaps run a clearing pass, and no item is accepted until both are done.
// ----------------------------------------------------------------------------
module inode_block_allocator #(
  parameter int NUM_BLOCKS       = 1024,
  parameter int NUM_INODES       = 256,
  parameter int BLOCKS_PER_INODE = 12,
  parameter int BLOCK_BYTES      = 1024,
  parameter int RESERVED_BLOCKS  = 19,
  parameter int ROOT_INODE       = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  iba_pkg::iba_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output iba_pkg::iba_out_t out_data_o
);

  localparam int BIW  = $clog2(NUM_BLOCKS);
  localparam int INW  = $clog2(NUM_INODES);
  localparam int LAW  = $clog2(NUM_INODES * BLOCKS_PER_INODE);
  localparam int FCW  = $clog2(NUM_BLOCKS + 1);
  localparam int LBB  = $clog2(BLOCK_BYTES);

  localparam logic [3:0] S_INIT   = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_AI     = 4'd2;
  localparam logic [3:0] S_CHK    = 4'd3;
  localparam logic [3:0] S_GROW   = 4'd4;
  localparam logic [3:0] S_GROW_W = 4'd5;
  localparam logic [3:0] S_REL_RD = 4'd6;
  localparam logic [3:0] S_REL_D  = 4'd7;
  localparam logic [3:0] S_REL_W  = 4'd8;
  localparam logic [3:0] S_FIN    = 4'd9;
  localparam logic [3:0] S_FIN_W  = 4'd10;
  localparam logic [3:0] S_EMIT   = 4'd11;

  logic [3:0]        state_q, nxt_q;
  logic [1:0]        mode_q;
  logic [INW-1:0]    ino_q;
  logic [7:0]        ino_raw_q;
  logic [3:0]        req_q, h_q, k_q;
  logic [BIW-1:0]    blk_q;
  logic [FCW-1:0]    free_count_q;
  logic              root_wr_q;
  iba_pkg::iba_out_t res_q;
  iba_pkg::iba_out_t out_q;
  logic              out_valid_q;
  logic              out_free;

  // Bitmaps
  logic                 ibm_cmd_valid, bbm_cmd_valid;
  iba_pkg::iba_bm_cmd_t ibm_cmd, bbm_cmd;
  logic                 ibm_ready, bbm_ready;
  logic                 ibm_rsp_valid, bbm_rsp_valid;
  iba_pkg::iba_bm_rsp_t ibm_rsp, bbm_rsp;

  // Block list and held-count RAMs
  logic [BIW-1:0] list_mem [NUM_INODES * BLOCKS_PER_INODE];
  logic [BIW-1:0] list_rdata_q;
  logic           list_we;
  logic [LAW-1:0] list_addr;
  logic [3:0]     held_mem [NUM_INODES];
  logic [3:0]     held_rdata_q;
  logic           held_we;
  logic [INW-1:0] held_waddr;
  logic [3:0]     held_wdata;
  logic [INW-1:0] held_raddr;
  logic [3:0]     held_eff;

  // Input decode
  logic [16:0]    req_full;
  logic           in_range;
  logic [INW-1:0] in_ino;
  logic [2:0]     idle_status;

  assign req_full = ({1'b0, in_data_i.size_bytes} + 17'(BLOCK_BYTES - 1)) >> LBB;
  assign in_range = int'(in_data_i.inode) < NUM_INODES;
  assign in_ino   = INW'(in_data_i.inode);
  assign out_free = !out_valid_q || out_ready_i;

  // Errors known from the input alone: block limit first, then inode range
  assign idle_status =
      (in_data_i.mode == iba_pkg::MODE_RESIZE && req_full > 17'(BLOCKS_PER_INODE)) ?
        iba_pkg::ST_TOO_MANY :
      ((in_data_i.mode == iba_pkg::MODE_FREE ||
        in_data_i.mode == iba_pkg::MODE_RESIZE) && !in_range) ?
        iba_pkg::ST_UNUSED : iba_pkg::ST_OK;

  assign held_raddr = (state_q == S_IDLE) ? in_ino : ino_q;
  assign held_eff   = (int'(ino_q) == ROOT_INODE && !root_wr_q) ? 4'd0 : held_rdata_q;
  assign list_addr  = LAW'(int'(ino_q) * BLOCKS_PER_INODE + int'(k_q));

  iba_bitmap #(
    .DEPTH  (NUM_INODES),
    .SET_LO (ROOT_INODE),
    .SET_HI (ROOT_INODE + 1)
  ) u_ibm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (ibm_cmd_valid),
    .cmd_i       (ibm_cmd),
    .ready_o     (ibm_ready),
    .rsp_valid_o (ibm_rsp_valid),
    .rsp_o       (ibm_rsp)
  );

  iba_bitmap #(
    .DEPTH  (NUM_BLOCKS),
    .SET_LO (0),
    .SET_HI (RESERVED_BLOCKS)
  ) u_bbm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (bbm_cmd_valid),
    .cmd_i       (bbm_cmd),
    .ready_o     (bbm_ready),
    .rsp_valid_o (bbm_rsp_valid),
    .rsp_o       (bbm_rsp)
  );

  // Bitmap commands and RAM writes
  always_comb begin
    ibm_cmd_valid = 1'b0;
    ibm_cmd.op    = iba_pkg::BM_TEST;
    ibm_cmd.idx   = iba_pkg::BmIdxW'(in_ino);
    bbm_cmd_valid = 1'b0;
    bbm_cmd.op    = iba_pkg::BM_FIND;
    bbm_cmd.idx   = iba_pkg::BmIdxW'(list_rdata_q);
    list_we       = 1'b0;
    held_we       = 1'b0;
    held_waddr    = ino_q;
    held_wdata    = 4'd0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (in_data_i.mode == iba_pkg::MODE_ALLOC) begin
            ibm_cmd_valid = 1'b1;
            ibm_cmd.op    = iba_pkg::BM_FIND;
          end else if ((in_data_i.mode == iba_pkg::MODE_FREE ||
                        (in_data_i.mode == iba_pkg::MODE_RESIZE &&
                         req_full <= 17'(BLOCKS_PER_INODE))) && in_range) begin
            ibm_cmd_valid = 1'b1;
          end
        end
      end
      S_AI: begin
        if (ibm_rsp_valid && ibm_rsp.found) begin
          held_we    = 1'b1;
          held_waddr = INW'(ibm_rsp.idx);
        end
      end
      S_CHK: begin
        if (ibm_rsp_valid && ibm_rsp.prev && mode_q == iba_pkg::MODE_FREE && held_eff == 4'd0) begin
          held_we = 1'b1;
        end
      end
      S_GROW: begin
        bbm_cmd_valid = 1'b1;
      end
      S_GROW_W: begin
        if (bbm_rsp_valid && bbm_rsp.found) begin
          list_we    = 1'b1;
          held_we    = 1'b1;
          held_wdata = 4'(k_q + 1'b1);
        end
      end
      S_REL_D: begin
        bbm_cmd_valid = 1'b1;
        bbm_cmd.op    = iba_pkg::BM_CLEAR;
      end
      S_REL_W: begin
        if (bbm_rsp_valid && 4'(k_q + 1'b1) == h_q) begin
          held_we    = 1'b1;
          held_wdata = (mode_q == iba_pkg::MODE_FREE) ? 4'd0 : req_q;
        end
      end
      S_FIN: begin
        ibm_cmd_valid = 1'b1;
        ibm_cmd.op    = iba_pkg::BM_CLEAR;
        ibm_cmd.idx   = iba_pkg::BmIdxW'(ino_q);
      end
      default: begin
        list_we = 1'b0;
      end
    endcase
  end

  // Block list RAM
  always_ff @(posedge clk_i) begin
    if (list_we) begin
      list_mem[list_addr] <= BIW'(bbm_rsp.idx);
    end
    list_rdata_q <= list_mem[list_addr];
  end

  // Held-count RAM
  always_ff @(posedge clk_i) begin
    if (held_we) begin
      held_mem[held_waddr] <= held_wdata;
    end
    held_rdata_q <= held_mem[held_raddr];
  end

  // Control sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_INIT;
      nxt_q        <= S_IDLE;
      free_count_q <= FCW'(NUM_BLOCKS - RESERVED_BLOCKS);
      root_wr_q    <= 1'b0;
      out_valid_q  <= 1'b0;
      k_q          <= '0;
    end else begin
      if (state_q == S_EMIT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (held_we && int'(held_waddr) == ROOT_INODE) begin
        root_wr_q <= 1'b1;
      end
      case (state_q)
        S_INIT: begin
          if (ibm_ready && bbm_ready) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid_i) begin
            nxt_q <= S_IDLE;
            if (in_data_i.mode == iba_pkg::MODE_ALLOC) begin
              state_q <= S_AI;
            end else if (ibm_cmd_valid) begin
              state_q <= S_CHK;
            end else begin
              state_q <= S_EMIT;
            end
          end
        end
        S_AI: begin
          if (ibm_rsp_valid) begin
            state_q <= S_EMIT;
          end
        end
        S_CHK: begin
          if (ibm_rsp_valid) begin
            state_q <= S_EMIT;
            if (ibm_rsp.prev) begin
              if (mode_q == iba_pkg::MODE_FREE) begin
                k_q <= '0;
                if (held_eff == 4'd0) begin
                  state_q <= S_FIN;
                end else begin
                  state_q <= S_REL_RD;
                end
              end else if (req_q > held_eff) begin
                if (free_count_q >= FCW'(4'(req_q - held_eff))) begin
                  k_q     <= held_eff;
                  state_q <= S_GROW;
                end
              end else if (req_q < held_eff) begin
                k_q     <= req_q;
                state_q <= S_REL_RD;
              end
            end
          end
        end
        S_GROW: begin
          state_q <= S_GROW_W;
        end
        S_GROW_W: begin
          if (bbm_rsp_valid) begin
            state_q <= S_EMIT;
            if (!bbm_rsp.found) begin
              nxt_q <= S_IDLE;
            end else begin
              free_count_q <= FCW'(free_count_q - 1'b1);
              k_q          <= 4'(k_q + 1'b1);
              nxt_q        <= (4'(k_q + 1'b1) == req_q) ? S_IDLE : S_GROW;
            end
          end
        end
        S_REL_RD: begin
          state_q <= S_REL_D;
        end
        S_REL_D: begin
          state_q <= S_REL_W;
        end
        S_REL_W: begin
          if (bbm_rsp_valid) begin
            if (bbm_rsp.prev) begin
              free_count_q <= FCW'(free_count_q + 1'b1);
            end
            k_q <= 4'(k_q + 1'b1);
            if (4'(k_q + 1'b1) == h_q) begin
              nxt_q   <= S_IDLE;
              state_q <= (mode_q == iba_pkg::MODE_FREE) ? S_FIN : S_EMIT;
            end else begin
              nxt_q   <= S_REL_RD;
              state_q <= S_EMIT;
            end
          end
        end
        S_FIN: begin
          state_q <= S_FIN_W;
        end
        S_FIN_W: begin
          if (ibm_rsp_valid) begin
            nxt_q   <= S_IDLE;
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            state_q <= nxt_q;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Item context and result payload
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        mode_q    <= in_data_i.mode;
        ino_q     <= in_ino;
        ino_raw_q <= in_data_i.inode;
        req_q     <= req_full[3:0];
        res_q     <= '{block: '0, block_event: iba_pkg::EV_NONE, inode_out: in_data_i.inode,
                       status: idle_status, last: 1'b1};
      end
      S_AI: begin
        if (ibm_rsp_valid) begin
          if (ibm_rsp.found) begin
            res_q.inode_out <= 8'(ibm_rsp.idx);
          end else begin
            res_q.inode_out <= '0;
            res_q.status    <= iba_pkg::ST_NO_INODE;
          end
        end
      end
      S_CHK: begin
        if (ibm_rsp_valid) begin
          h_q <= held_eff;
          if (!ibm_rsp.prev) begin
            res_q.status <= iba_pkg::ST_UNUSED;
          end else if (mode_q == iba_pkg::MODE_RESIZE && req_q > held_eff &&
                       free_count_q < FCW'(4'(req_q - held_eff))) begin
            res_q.status <= iba_pkg::ST_FULL;
          end
        end
      end
      S_GROW_W: begin
        if (!bbm_rsp.found) begin
          res_q <= '{block: '0, block_event: iba_pkg::EV_NONE, inode_out: ino_raw_q,
                     status: iba_pkg::ST_FULL, last: 1'b1};
        end else begin
          res_q <= '{block: 10'(bbm_rsp.idx), block_event: iba_pkg::EV_ALLOC,
                     inode_out: ino_raw_q, status: iba_pkg::ST_OK,
                     last: (4'(k_q + 1'b1) == req_q)};
        end
      end
      S_REL_D: begin
        blk_q <= list_rdata_q;
      end
      S_REL_W: begin
        res_q <= '{block: 10'(blk_q), block_event: iba_pkg::EV_RELEASE,
                   inode_out: ino_raw_q, status: iba_pkg::ST_OK,
                   last: (4'(k_q + 1'b1) == h_q)};
      end
      default: begin
        res_q <= res_q;
      end
    endcase
    if (state_q == S_EMIT && out_free) begin
      out_q <= res_q;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
